// ===== src/multichannel_moving_average_unit_macros.svh =====
// Assertion macros for the multichannel moving average unit.
// Used by the port checker; depends on nothing else.
`ifndef MULTICHANNEL_MOVING_AVERAGE_UNIT_MACROS_SVH
`define MULTICHANNEL_MOVING_AVERAGE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMAU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MMAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after reset is seen.
`define MMAU_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/mmau_pkg.sv =====
// Package of the multichannel moving average unit: payload types, codes and widths.
// Used by the top level, the divider and the port checker; depends on nothing.
package mmau_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int CHANNEL_W  = 3;
   localparam int WINDOW_W   = 11;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   localparam logic REG_WINDOW_LENGTH = 1'b0;

   typedef struct packed {
      logic                        command;
      logic [CHANNEL_W-1:0]        channel;
      logic signed [SAMPLE_W-1:0]  sample;
   } req_payload_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0]        out_channel;
      logic signed [SAMPLE_W-1:0]  average;
   } rsp_payload_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== src/mmau_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Stands alone; used for the sample ring and the channel state.
module mmau_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/mmau_divider.sv =====
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Depends on mmau_pkg for the status struct.
module mmau_divider #(
   parameter int DVD_W = 34,
   parameter int DVS_W = 11
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DVD_W-1:0]         dividend,
   input  logic [DVS_W-1:0]         divisor,
   output logic [DVD_W-1:0]         quotient,
   output mmau_pkg::div_status_type status
);
   import mmau_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   rem_shift;
   logic [DVS_W:0]   diff;

   always_comb begin
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      rem_shift = {rem_ff, quo_ff[DVD_W-1]};
      diff      = rem_shift - {1'b0, dvs_ff};
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
         count_in = CNT_W'(DVD_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DVS_W]) begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      count_ff <= count_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== src/multichannel_moving_average_unit.sv =====
// Top level of the multichannel moving average unit: control, register port and memories.
// Depends on mmau_pkg, mmau_ram and mmau_divider.
//
// Each item on the req channel either clears all channels or carries one sample
// for one channel. A sample item gives one item on the rsp channel holding the
// boxcar average of that channel's recent samples, truncated toward zero. Clear
// items and items for a channel of CHANNELS or above give no result.
// The window length register lies at byte address 0 of the csr port. It is clamped
// to the ring depth, at most 2047; a zero write gives one. Every write to it clears all channels.
// A sample item passes from acceptance through the lookup, update, launch, divide and
// output states before its result is offered. The bit-serial divider works one
// quotient bit per cycle over the running sum width. With a window length of one
// the sample goes from idle straight to the output state and is passed through.
// A clear item is handled in the idle state alone. One item is worked on at a time,
// so no new item is accepted until the last sample item has left the output state.
// Results go to an output register, so the next item is accepted while a result
// waits; when the receiver stalls, the block holds its finished result and
// stops accepting after that.
// Reset sets the window length to one and empties all channels at once through
// per-channel valid bits. The sample ring needs no clearing.
module multichannel_moving_average_unit #(
   parameter int RING_DEPTH = 1024,
   parameter int CHANNELS   = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  mmau_pkg::req_payload_type              req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output mmau_pkg::rsp_payload_type              rsp_payload,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [mmau_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [mmau_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [mmau_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);
   import mmau_pkg::*;

   localparam int WIN_MAX  = (RING_DEPTH < 2047) ? RING_DEPTH : 2047;
   localparam int SUM_W    = SAMPLE_W + $clog2(WIN_MAX);
   localparam int FILL_W   = $clog2(WIN_MAX + 1);
   localparam int POS_W    = $clog2(WIN_MAX);
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int RING_AW  = $clog2(CHANNELS * RING_DEPTH);
   localparam int ST_W     = SUM_W + FILL_W + POS_W;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_LOOKUP = 6'b000010,
      S_UPDATE = 6'b000100,
      S_LAUNCH = 6'b001000,
      S_DIVIDE = 6'b010000,
      S_OUT    = 6'b100000
   } state_type;

   state_type                  state_ff, state_in;
   logic [WINDOW_W-1:0]        window_ff, window_in;
   logic [CHANNELS-1:0]        st_valid_ff, st_valid_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_payload_type            rsp_ff, rsp_in;
   logic [CH_W-1:0]            ch_ff, ch_in;
   logic [SAMPLE_W-1:0]        sample_ff, sample_in;
   logic [RING_AW-1:0]         ring_base_ff, ring_base_in;
   logic [RING_AW-1:0]         slot_ff, slot_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic                       neg_ff, neg_in;
   logic                       pass_ff, pass_in;

   logic                       st_rd_en, st_wr_en;
   logic [CH_W-1:0]            st_rd_addr;
   logic [ST_W-1:0]            st_rd_data, st_wr_data;
   logic                       ring_rd_en, ring_wr_en;
   logic [SAMPLE_W-1:0]        ring_rd_data;

   logic                       div_start;
   logic [SUM_W-1:0]           div_dividend;
   logic [SUM_W-1:0]           div_quotient;
   div_status_type             div_status;

   logic                       csr_write;
   logic [WINDOW_W-1:0]        wr_value;
   logic                       ch_in_range;
   logic                       entry_valid;
   logic [SUM_W-1:0]           old_sum;
   logic [FILL_W-1:0]          old_fill;
   logic [POS_W-1:0]           old_pos;
   logic [POS_W-1:0]           pos_eff;
   logic                       full;
   logic [SUM_W-1:0]           new_sum;
   logic [FILL_W-1:0]          new_fill;
   logic [POS_W-1:0]           new_pos;
   logic [WINDOW_W-1:0]        pos_next;
   logic [SAMPLE_W-1:0]        q_mag;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[CSR_ADDR_W-1] == REG_WINDOW_LENGTH);
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_WINDOW_LENGTH) ?
                       CSR_DATA_W'(window_ff) : '0;
   assign wr_value   = csr_pwdata[WINDOW_W-1:0];

   assign req_ready   = (state_ff == S_IDLE);
   assign ch_in_range = 32'(req_payload.channel) < CHANNELS;

   assign entry_valid = st_valid_ff[ch_ff];
   assign old_sum     = entry_valid ? st_rd_data[ST_W-1 -: SUM_W] : '0;
   assign old_fill    = entry_valid ? st_rd_data[POS_W +: FILL_W] : '0;
   assign old_pos     = entry_valid ? st_rd_data[POS_W-1:0] : '0;
   assign pos_eff     = (WINDOW_W'(old_pos) >= window_ff) ? '0 : old_pos;

   assign full     = WINDOW_W'(fill_ff) >= window_ff;
   assign new_fill = full ? fill_ff : fill_ff + FILL_W'(1);
   assign new_sum  = sum_ff
                     - (full ? {{(SUM_W-SAMPLE_W){ring_rd_data[SAMPLE_W-1]}}, ring_rd_data}
                             : SUM_W'(0))
                     + {{(SUM_W-SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff};
   assign pos_next = WINDOW_W'(pos_ff) + WINDOW_W'(1);
   assign new_pos  = (pos_next >= window_ff) ? '0 : POS_W'(pos_next);

   assign st_wr_data   = {new_sum, new_fill, new_pos};
   assign div_dividend = sum_ff[SUM_W-1] ? -sum_ff : sum_ff;
   assign q_mag        = div_quotient[SAMPLE_W-1:0];

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      st_valid_in  = st_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      ch_in        = ch_ff;
      sample_in    = sample_ff;
      ring_base_in = ring_base_ff;
      slot_in      = slot_ff;
      sum_in       = sum_ff;
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      neg_in       = neg_ff;
      pass_in      = pass_ff;
      st_rd_en     = 1'b0;
      st_rd_addr   = CH_W'(req_payload.channel);
      st_wr_en     = 1'b0;
      ring_rd_en   = 1'b0;
      ring_wr_en   = 1'b0;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_payload.command == CMD_CLEAR) begin
                  st_valid_in = '0;
               end else if (ch_in_range) begin
                  ch_in        = CH_W'(req_payload.channel);
                  sample_in    = req_payload.sample;
                  ring_base_in = RING_AW'(32'(req_payload.channel) * 32'(RING_DEPTH));
                  if (window_ff == WINDOW_W'(1)) begin
                     pass_in  = 1'b1;
                     state_in = S_OUT;
                  end else begin
                     pass_in  = 1'b0;
                     st_rd_en = 1'b1;
                     state_in = S_LOOKUP;
                  end
               end
            end
         end
         S_LOOKUP: begin
            slot_in    = ring_base_ff + RING_AW'(pos_eff);
            ring_rd_en = 1'b1;
            sum_in     = old_sum;
            fill_in    = old_fill;
            pos_in     = pos_eff;
            state_in   = S_UPDATE;
         end
         S_UPDATE: begin
            st_wr_en           = 1'b1;
            ring_wr_en         = 1'b1;
            st_valid_in[ch_ff] = 1'b1;
            sum_in             = new_sum;
            fill_in            = new_fill;
            state_in           = S_LAUNCH;
         end
         S_LAUNCH: begin
            div_start = 1'b1;
            neg_in    = sum_ff[SUM_W-1];
            state_in  = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (div_status.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.out_channel = CHANNEL_W'(ch_ff);
               rsp_in.average     = pass_ff ? sample_ff : (neg_ff ? -q_mag : q_mag);
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_write) begin
         st_valid_in = '0;
         if (wr_value == '0) begin
            window_in = WINDOW_W'(1);
         end else if (32'(wr_value) > WIN_MAX) begin
            window_in = WINDOW_W'(WIN_MAX);
         end else begin
            window_in = wr_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         window_ff    <= WINDOW_W'(1);
         st_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         st_valid_ff  <= st_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff       <= rsp_in;
      ch_ff        <= ch_in;
      sample_ff    <= sample_in;
      ring_base_ff <= ring_base_in;
      slot_ff      <= slot_in;
      sum_ff       <= sum_in;
      fill_ff      <= fill_in;
      pos_ff       <= pos_in;
      neg_ff       <= neg_in;
      pass_ff      <= pass_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   mmau_ram #(
      .WIDTH (ST_W),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (ch_ff),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   mmau_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (CHANNELS * RING_DEPTH)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_en   (ring_rd_en),
      .rd_addr (slot_in),
      .rd_data (ring_rd_data)
   );

   mmau_divider #(
      .DVD_W (SUM_W),
      .DVS_W (FILL_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (fill_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

endmodule

// ===== src/mmau_checker.sv =====
// Port checker of the multichannel moving average unit, bound to the top level.
// Depends on mmau_pkg and the assertion macro header.
`include "multichannel_moving_average_unit_macros.svh"

module mmau_checker #(
   parameter int CHANNELS = 8
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input mmau_pkg::req_payload_type       req_payload,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input mmau_pkg::rsp_payload_type       rsp_payload,
   input logic                            csr_psel,
   input logic                            csr_pwrite,
   input logic [mmau_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [mmau_pkg::CSR_DATA_W-1:0] csr_prdata
);
   import mmau_pkg::*;

   logic sample_taken;
   logic window_read;
   logic window_legal;
   logic rsp_stalled;

   assign sample_taken = req_valid && req_ready && (req_payload.command == CMD_SAMPLE) &&
                         (32'(req_payload.channel) < CHANNELS);
   assign window_read  = csr_psel && (csr_paddr[CSR_ADDR_W-1] == REG_WINDOW_LENGTH) &&
                         !csr_pwrite;
   assign window_legal = (csr_prdata[WINDOW_W-1:0] != '0) &&
                         (csr_prdata[CSR_DATA_W-1:WINDOW_W] == '0);
   assign rsp_stalled  = rsp_valid && !rsp_ready;

   `MMAU_ASSERT_AFTER_RESET(a_reset_idle, clock, reset, !rsp_valid && req_ready)
   `MMAU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid && $stable(rsp_payload))
   `MMAU_ASSERT_NEXT(a_busy_after_sample, clock, reset, sample_taken, !req_ready)
   `MMAU_ASSERT_SAME(a_window_legal, clock, reset, window_read, window_legal)

endmodule

bind multichannel_moving_average_unit mmau_checker #(.CHANNELS(CHANNELS)) u_checker (.*);

// ===== bench/multichannel_moving_average_unit_tb.sv =====
// Testbench for multichannel_moving_average_unit: a queue-fed driver, a checking monitor
// and a boxcar average predictor, with window length writes between phases of traffic.
// Depends on mmau_pkg and the RTL of the unit.
module multichannel_moving_average_unit_tb;
   import mmau_pkg::*;

   localparam int RING_DEPTH = 1024;
   localparam int CHANNELS = 8;
   localparam int DRAIN_CYCLES = 60;
   localparam int ITEM_TARGET = 1150;
   localparam int CALM_ITEMS = 150;
   localparam logic [CSR_ADDR_W-1:0] WINDOW_REG_ADDR = {REG_WINDOW_LENGTH, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] UNUSED_REG_ADDR = 3'd4;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   req_payload_type pending_items[$];
   rsp_payload_type expected_averages[$];
   int failures = 0;
   bit calm = 1'b0;
   int send_gap = 0;
   int hold_off = 0;

   logic signed [SAMPLE_W-1:0] history[CHANNELS][RING_DEPTH];
   longint window_sum[CHANNELS];
   int unsigned seen_count[CHANNELS];
   int unsigned next_slot[CHANNELS];
   int unsigned window_len = 1;

   int notable_windows[13] = '{1, 2, 3, 5, 8, 16, 33, 255, 1023, 1024, 0, 2047, 65541};

   multichannel_moving_average_unit #(
      .RING_DEPTH(RING_DEPTH),
      .CHANNELS(CHANNELS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   function automatic void clear_history();
      for (int c = 0; c < CHANNELS; c++) begin
         window_sum[c] = 0;
         seen_count[c] = 0;
         next_slot[c] = 0;
      end
   endfunction

   function automatic void predict_average(req_payload_type item);
      int unsigned ch;
      int unsigned slot;
      longint s;
      longint avg;
      rsp_payload_type result;
      if (item.command == CMD_CLEAR) begin
         clear_history();
         return;
      end
      ch = item.channel;
      if (ch >= CHANNELS) return;
      s = item.sample;
      if (window_len <= 1) begin
         avg = s;
      end else begin
         slot = next_slot[ch];
         if (slot >= window_len) slot = 0;
         if (seen_count[ch] < window_len) seen_count[ch]++;
         else window_sum[ch] -= longint'(history[ch][slot]);
         window_sum[ch] += s;
         history[ch][slot] = item.sample;
         slot++;
         if (slot >= window_len) slot = 0;
         next_slot[ch] = slot;
         avg = window_sum[ch] / longint'(seen_count[ch]);
      end
      result.out_channel = ch[CHANNEL_W-1:0];
      result.average = avg[SAMPLE_W-1:0];
      expected_averages.push_back(result);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 15))
         0, 1: begin
            return SAMPLE_MAX;
         end
         2, 3: begin
            return SAMPLE_MIN;
         end
         4: begin
            return SAMPLE_W'($signed($urandom_range(0, 6)) - 3);
         end
         default: begin
            return SAMPLE_W'($urandom());
         end
      endcase
   endfunction

   function automatic void enqueue_sample(int unsigned ch, logic signed [SAMPLE_W-1:0] s);
      req_payload_type item;
      item.command = CMD_SAMPLE;
      item.channel = ch[CHANNEL_W-1:0];
      item.sample = s;
      pending_items.push_back(item);
   endfunction

   function automatic void enqueue_clear();
      req_payload_type item;
      item.command = CMD_CLEAR;
      item.channel = CHANNEL_W'($urandom());
      item.sample = SAMPLE_W'($urandom());
      pending_items.push_back(item);
   endfunction

   task automatic write_csr(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] value);
      int unsigned len;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr[CSR_ADDR_W-1:2] == REG_WINDOW_LENGTH) begin
         len = value[WINDOW_W-1:0];
         if (len < 1) len = 1;
         if (len > RING_DEPTH) len = RING_DEPTH;
         window_len = len;
         clear_history();
      end
   endtask

   task automatic wait_until_drained();
      while (pending_items.size() != 0 || req_valid || expected_averages.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) predict_average(req_payload);
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_valid <= 1'b1;
            req_payload <= pending_items.pop_front();
            if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 14);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_averages.size() == 0) begin
               $error("unexpected item: out_channel %0d average %0d",
                      rsp_payload.out_channel, rsp_payload.average);
               failures++;
            end else begin
               want = expected_averages.pop_front();
               if (rsp_payload.out_channel !== want.out_channel) begin
                  $error("out_channel mismatch: expected %0d, actual %0d",
                         want.out_channel, rsp_payload.out_channel);
                  failures++;
               end
               if (rsp_payload.average !== want.average) begin
                  $error("average mismatch: expected %0d, actual %0d",
                         want.average, rsp_payload.average);
                  failures++;
               end
            end
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0) hold_off = $urandom_range(1, 14);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int raw_window;
      int unsigned eff_window;
      int phase_items;
      int total;
      int unsigned ch_a;
      int unsigned ch_b;
      bit focused;
      clear_history();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // After reset the window is one sample wide, so samples pass straight through.
      enqueue_sample(0, SAMPLE_MAX);
      enqueue_sample(1, SAMPLE_MIN);
      enqueue_sample(2, 0);
      enqueue_sample(7, -1);
      enqueue_clear();
      wait_until_drained();

      // Negative sums must truncate toward zero.
      write_csr(WINDOW_REG_ADDR, 2);
      enqueue_sample(3, -1);
      enqueue_sample(3, -2);
      enqueue_sample(3, -1);
      enqueue_sample(3, 3);
      enqueue_sample(5, SAMPLE_MIN);
      enqueue_sample(5, SAMPLE_MIN);
      wait_until_drained();

      // A write to an unknown register must leave the channels alone.
      write_csr(UNUSED_REG_ADDR, 7);
      enqueue_sample(3, 0);
      wait_until_drained();

      write_csr(WINDOW_REG_ADDR, 0);
      enqueue_sample(4, 12345);
      wait_until_drained();

      write_csr(WINDOW_REG_ADDR, 2047);
      enqueue_sample(7, SAMPLE_MAX);
      enqueue_sample(7, SAMPLE_MAX);
      enqueue_sample(7, SAMPLE_MAX);
      enqueue_sample(7, SAMPLE_MIN);
      enqueue_sample(6, SAMPLE_MIN);
      enqueue_sample(6, SAMPLE_MIN);
      enqueue_clear();
      enqueue_sample(7, 5);
      wait_until_drained();
      total = 20;

      while (total < ITEM_TARGET - CALM_ITEMS) begin
         if ($urandom_range(0, 2) == 0) raw_window = $urandom_range(0, 40);
         else raw_window = notable_windows[$urandom_range(0, 12)];
         write_csr(WINDOW_REG_ADDR, raw_window);
         eff_window = window_len;
         phase_items = (eff_window > 64) ? $urandom_range(30, 50) : $urandom_range(80, 140);
         focused = $urandom_range(0, 1);
         ch_a = $urandom_range(0, CHANNELS - 1);
         ch_b = $urandom_range(0, CHANNELS - 1);
         repeat (phase_items) begin
            if ($urandom_range(0, 29) == 0) enqueue_clear();
            else if (focused) enqueue_sample($urandom_range(0, 1) ? ch_a : ch_b, random_sample());
            else enqueue_sample($urandom_range(0, CHANNELS - 1), random_sample());
         end
         total += phase_items;
         wait_until_drained();
      end

      // The closing stretch runs with both sides at full rate.
      calm = 1'b1;
      write_csr(WINDOW_REG_ADDR, $urandom_range(2, 12));
      repeat (CALM_ITEMS) begin
         if ($urandom_range(0, 29) == 0) enqueue_clear();
         else enqueue_sample($urandom_range(0, CHANNELS - 1), random_sample());
      end
      wait_until_drained();

      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

// ===== multichannel_moving_average_unit.f =====
+incdir+src
src/mmau_pkg.sv
src/mmau_ram.sv
src/mmau_divider.sv
src/multichannel_moving_average_unit.sv
src/mmau_checker.sv
bench/multichannel_moving_average_unit_tb.sv
